// ===== rtl/pcfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfa_pkg: shared types and helpers for the pairwise color force accumulator
// Item opcodes, register indexes, sequencer states, unit control structs and
// Q16.16 saturation helpers.
// ----------------------------------------------------------------------------
package pcfa_pkg;

  localparam int unsigned MaxColors = 16;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;

  localparam logic [30:0] HalfWidthRst = 31'd65536;
  localparam logic [30:0] RadiusRst    = 31'd6554;
  localparam logic [15:0] RepFracRst   = 16'd19661;
  localparam logic [30:0] FrictionRst  = 31'd65536;
  localparam logic [30:0] InvDtRst     = 31'd3932160;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_START    = 2'd1,
    OP_NEIGHBOR = 2'd2,
    OP_FINISH   = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HALF_WIDTH = 3'd0,
    REG_RADIUS     = 3'd1,
    REG_REP_FRAC   = 3'd2,
    REG_FRICTION   = 3'd3,
    REG_INV_DT     = 3'd4
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_VX, ST_FX, ST_AX, ST_FY, ST_AY,
    ST_NDIFF, ST_WRAP1, ST_WRAP2, ST_CHK,
    ST_SQX, ST_SQY, ST_SQS, ST_RR, ST_SQW, ST_SEL,
    ST_DR, ST_DA, ST_DT, ST_DS,
    ST_UXS, ST_UXW, ST_FXN, ST_UYW, ST_FYN
  } state_e;

  // control into / status out of the shared divide / square root unit
  typedef struct packed {
    logic start;
    logic sqrt;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [49:0] apply_sign(input logic [48:0] m, input logic neg);
    logic signed [49:0] p;
    p = signed'({1'b0, m});
    return neg ? -p : p;
  endfunction

endpackage

// ===== rtl/pcfa_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfa_if: item and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface pcfa_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] prev_x;
  logic signed [31:0] prev_y;
  logic [3:0]         color;
  logic [3:0]         column_color;
  logic [11:0]        particle_id;
  logic signed [31:0] scale_value;

  modport source (output valid, op, px, py, prev_x, prev_y, color, column_color,
                  particle_id, scale_value, input ready);
  modport sink (input valid, op, px, py, prev_x, prev_y, color, column_color,
                particle_id, scale_value, output ready);
endinterface

interface pcfa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic [11:0]        result_id;

  modport source (output valid, force_x, force_y, result_id, input ready);
  modport sink (input valid, force_x, force_y, result_id, output ready);
endinterface

// ===== rtl/pcfa_iter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfa_iter_unit: shared restoring divider / integer square root
// One subtract-compare per cycle: 48 steps for a divide, 32 for a root.
// ----------------------------------------------------------------------------
module pcfa_iter_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pcfa_pkg::unit_req_t   req_i,
  input  logic [63:0]           src_i,   // radicand, or numerator in [63:16]
  input  logic [31:0]           den_i,
  output pcfa_pkg::unit_stat_t  stat_o,
  output logic [47:0]           res_o
);
  import pcfa_pkg::*;

  logic        busy_q, busy_d, done_q, done_d, sqrt_q, sqrt_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [35:0] rem_q, rem_d;
  logic [63:0] src_q, src_d;
  logic [31:0] den_q, den_d;
  logic [47:0] res_q, res_d;

  logic [35:0] shifted, trial;
  logic [36:0] diff;
  logic        ge;
  logic [5:0]  last;

  always_comb begin
    shifted = sqrt_q ? {rem_q[33:0], src_q[63:62]} : {rem_q[34:0], src_q[63]};
    trial   = sqrt_q ? {2'b00, res_q[31:0], 2'b01} : {4'b0000, den_q};
    diff    = {1'b0, shifted} - {1'b0, trial};
    ge      = ~diff[36];
    last    = sqrt_q ? 6'd31 : 6'd47;

    busy_d = busy_q;
    done_d = 1'b0;
    sqrt_d = sqrt_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    src_d  = src_q;
    den_d  = den_q;
    res_d  = res_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      sqrt_d = req_i.sqrt;
      cnt_d  = '0;
      rem_d  = '0;
      src_d  = src_i;
      den_d  = den_i;
      res_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[35:0] : shifted;
      res_d = {res_q[46:0], ge};
      src_d = sqrt_q ? {src_q[61:0], 2'b00} : {src_q[62:0], 1'b0};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sqrt_q <= sqrt_d;
    rem_q  <= rem_d;
    src_q  <= src_d;
    den_q  <= den_d;
    res_q  <= res_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/pcfa_scale_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfa_scale_mem: color-pair scale table
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pcfa_scale_mem #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AddrW-1:0]   waddr_i,
  input  logic signed [31:0] wdata_i,
  input  logic [AddrW-1:0]   raddr_i,
  output logic signed [31:0] rdata_o
);
  import pcfa_pkg::*;

  logic signed [31:0] mem_q [Depth];
  logic signed [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pairwise_color_force_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_color_force_accumulator: particle-life net force on one particle
// Sequencer around one 33x32 multiplier and one shared divide/root unit.
// ----------------------------------------------------------------------------
// Sequencing: a load writes the table on its transfer; a finish result is
//   registered on its transfer; start and neighbor keep the block busy, the
//   neighbor for a 32-step root and then up to three 48-step divides in the
//   shared unit unless rejected early. Items are taken one at a time.
// Reset: async active low; registers take their defaults, position, id and
//   force accumulator clear; the scale table is not cleared.
// ----------------------------------------------------------------------------
module pairwise_color_force_accumulator #(
  parameter int unsigned MAX_COLORS = pcfa_pkg::MaxColors
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcfa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pcfa_pkg::CfgDataW-1:0] cfg_wdata_i,
  pcfa_in_if.sink                       in_i,
  pcfa_out_if.source                    out_o
);
  import pcfa_pkg::*;

  localparam int unsigned Depth = MAX_COLORS * MAX_COLORS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  // configuration registers
  logic [30:0] hw_q, rad_q, fric_q, its_q;
  logic [15:0] frac_q;

  // particle state
  state_e             state_q, state_d;
  logic signed [31:0] own_x_q, own_x_d, own_y_q, own_y_d;
  logic [3:0]         own_col_q, own_col_d;
  logic [11:0]        own_id_q, own_id_d;
  logic signed [31:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d;

  // latched item
  logic signed [31:0] it_px_q, it_px_d, it_py_q, it_py_d;
  logic signed [31:0] it_prx_q, it_prx_d, it_pry_q, it_pry_d;
  logic [3:0]         it_col_q, it_col_d;
  logic [11:0]        it_id_q, it_id_d;

  // datapath registers
  logic                 sg_q, sg_d, sx_q, sx_d, sy_q, sy_d;
  logic signed [34:0]   dx_q, dx_d, dy_q, dy_d;
  logic [30:0]          adx_q, adx_d, ady_q, ady_d;
  logic [62:0]          d2_q, d2_d;
  logic [30:0]          rr_q, rr_d, dist_q, dist_d;
  logic signed [31:0]   t_q, t_d, s_q, s_d;
  logic [64:0]          prod_q, prod_d;

  // result register
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] fx_q, fx_d, fy_q, fy_d;
  logic [11:0]        rid_q, rid_d;

  // shared multiplier
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic        mul_en;

  // shared divide / root unit
  unit_req_t   ureq;
  unit_stat_t  ustat;
  logic [63:0] usrc;
  logic [31:0] uden;
  logic [47:0] ures;

  // scale table
  logic               mem_we;
  logic [AddrW-1:0]   mem_waddr, mem_raddr;
  logic signed [31:0] mem_rdata;

  // combinational temporaries
  logic               in_fire;
  logic signed [32:0] dp;
  logic [32:0]        dp_mag;
  logic signed [31:0] vel;
  logic [31:0]        vel_mag;
  logic signed [34:0] hw_s, hw2_s, ax35, ay35;
  logic [31:0]        dist_w;
  logic signed [33:0] arg;
  logic [33:0]        arg_mag;
  logic signed [48:0] rm;
  logic signed [31:0] scale;
  logic [31:0]        t_mag, sc_mag, s_mag;
  logic               load_ok, pair_ok;

  function automatic logic [AddrW-1:0] tbl_addr(input logic [3:0] row, input logic [3:0] col);
    return AddrW'(32'(row) * 32'(MAX_COLORS) + 32'(col));
  endfunction

  function automatic logic color_ok(input logic [3:0] c);
    return 32'(c) < 32'(MAX_COLORS);
  endfunction

  assign in_fire     = in_i.valid & in_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE) & (~out_valid_q | out_o.ready);
  assign out_o.valid     = out_valid_q;
  assign out_o.force_x   = fx_q;
  assign out_o.force_y   = fy_q;
  assign out_o.result_id = rid_q;

  assign load_ok   = color_ok(in_i.color) & color_ok(in_i.column_color);
  assign pair_ok   = color_ok(own_col_q) & color_ok(it_col_q);
  assign mem_we    = in_fire & (op_e'(in_i.op) == OP_LOAD) & load_ok;
  assign mem_waddr = tbl_addr(in_i.color, in_i.column_color);
  assign mem_raddr = tbl_addr(own_col_q, it_col_q);

  // config write port; the user must write it only while the block is idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q   <= HalfWidthRst;
      rad_q  <= RadiusRst;
      frac_q <= RepFracRst;
      fric_q <= FrictionRst;
      its_q  <= InvDtRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_HALF_WIDTH: hw_q   <= cfg_wdata_i;
        REG_RADIUS:     rad_q  <= cfg_wdata_i;
        REG_REP_FRAC:   frac_q <= cfg_wdata_i[15:0];
        REG_FRICTION:   fric_q <= cfg_wdata_i;
        REG_INV_DT:     its_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    own_x_d  = own_x_q;
    own_y_d  = own_y_q;
    own_col_d = own_col_q;
    own_id_d = own_id_q;
    acc_x_d  = acc_x_q;
    acc_y_d  = acc_y_q;
    it_px_d  = it_px_q;
    it_py_d  = it_py_q;
    it_prx_d = it_prx_q;
    it_pry_d = it_pry_q;
    it_col_d = it_col_q;
    it_id_d  = it_id_q;
    sg_d = sg_q;
    sx_d = sx_q;
    sy_d = sy_q;
    dx_d = dx_q;
    dy_d = dy_q;
    adx_d = adx_q;
    ady_d = ady_q;
    d2_d  = d2_q;
    rr_d  = rr_q;
    dist_d = dist_q;
    t_d = t_q;
    s_d = s_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    fx_d  = fx_q;
    fy_d  = fy_q;
    rid_d = rid_q;

    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    ureq   = '0;
    usrc   = '0;
    uden   = '0;

    hw_s  = signed'({4'b0, hw_q});
    hw2_s = signed'({3'b0, hw_q, 1'b0});
    dp      = '0;
    dp_mag  = '0;
    vel     = '0;
    vel_mag = '0;
    ax35 = dx_q[34] ? -dx_q : dx_q;
    ay35 = dy_q[34] ? -dy_q : dy_q;
    dist_w  = ures[31:0];
    arg     = signed'({2'b0, dist_q, 1'b0}) - signed'({3'b0, rad_q}) - signed'({3'b0, rr_q});
    arg_mag = arg[33] ? -arg : arg;
    rm      = signed'({18'b0, rad_q}) - signed'({1'b0, ures});
    scale   = pair_ok ? mem_rdata : 32'sd0;
    t_mag   = t_q[31] ? -t_q : t_q;
    sc_mag  = scale[31] ? -scale : scale;
    s_mag   = s_q[31] ? -s_q : s_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          it_px_d  = in_i.px;
          it_py_d  = in_i.py;
          it_prx_d = in_i.prev_x;
          it_pry_d = in_i.prev_y;
          it_col_d = in_i.color;
          it_id_d  = in_i.particle_id;
          case (op_e'(in_i.op))
            OP_START: begin
              own_x_d   = in_i.px;
              own_y_d   = in_i.py;
              own_col_d = in_i.color;
              own_id_d  = in_i.particle_id;
              state_d   = ST_VX;
            end
            OP_NEIGHBOR: state_d = ST_NDIFF;
            OP_FINISH: begin
              out_valid_d = 1'b1;
              fx_d  = acc_x_q;
              fy_d  = acc_y_q;
              rid_d = own_id_q;
            end
            default: ;  // table load handled on the memory port
          endcase
        end
      end

      // friction seed: vel = dpos * inv_dt, acc = -(vel * gain)
      ST_VX, ST_AX: begin
        if (state_q == ST_VX) begin
          dp = 33'(it_px_q) - 33'(it_prx_q);
        end else begin
          dp = 33'(it_py_q) - 33'(it_pry_q);
          acc_x_d = sat32(apply_sign(prod_q[64:16], ~sg_q));
        end
        dp_mag = dp[32] ? -dp : dp;
        sg_d   = dp[32];
        mul_en = 1'b1;
        mul_a  = dp_mag;
        mul_b  = {1'b0, its_q};
        state_d = (state_q == ST_VX) ? ST_FX : ST_FY;
      end
      ST_FX, ST_FY: begin
        vel     = sat32(apply_sign(prod_q[64:16], sg_q));
        vel_mag = vel[31] ? -vel : vel;
        mul_en  = 1'b1;
        mul_a   = {1'b0, vel_mag};
        mul_b   = {1'b0, fric_q};
        state_d = (state_q == ST_FX) ? ST_AX : ST_AY;
      end
      ST_AY: begin
        acc_y_d = sat32(apply_sign(prod_q[64:16], ~sg_q));
        state_d = ST_IDLE;
      end

      // neighbor: skip own id, periodic offset, then radius gate
      ST_NDIFF: begin
        if (it_id_q == own_id_q) begin
          state_d = ST_IDLE;
        end else begin
          dx_d = 35'(it_px_q) - 35'(own_x_q);
          dy_d = 35'(it_py_q) - 35'(own_y_q);
          state_d = ST_WRAP1;
        end
      end
      ST_WRAP1: begin
        if (dx_q > hw_s) dx_d = dx_q - hw2_s;
        if (dy_q > hw_s) dy_d = dy_q - hw2_s;
        state_d = ST_WRAP2;
      end
      ST_WRAP2: begin
        if (dx_q < -hw_s) dx_d = dx_q + hw2_s;
        if (dy_q < -hw_s) dy_d = dy_q + hw2_s;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if ((ax35 > signed'({4'b0, rad_q})) || (ay35 > signed'({4'b0, rad_q}))) begin
          state_d = ST_IDLE;
        end else begin
          adx_d = ax35[30:0];
          ady_d = ay35[30:0];
          sx_d  = dx_q[34];
          sy_d  = dy_q[34];
          state_d = ST_SQX;
        end
      end
      ST_SQX: begin
        mul_en = 1'b1;
        mul_a  = {2'b0, adx_q};
        mul_b  = {1'b0, adx_q};
        state_d = ST_SQY;
      end
      ST_SQY: begin
        d2_d   = prod_q[62:0];
        mul_en = 1'b1;
        mul_a  = {2'b0, ady_q};
        mul_b  = {1'b0, ady_q};
        state_d = ST_SQS;
      end
      ST_SQS: begin
        d2_d   = d2_q + prod_q[62:0];
        mul_en = 1'b1;
        mul_a  = {2'b0, rad_q};
        mul_b  = {16'b0, frac_q};
        state_d = ST_RR;
      end
      ST_RR: begin
        rr_d      = prod_q[46:16];
        ureq.start = 1'b1;
        ureq.sqrt  = 1'b1;
        usrc       = {1'b0, d2_q};
        state_d    = ST_SQW;
      end
      ST_SQW: begin
        if (ustat.done) begin
          if ((dist_w == 32'd0) || (dist_w > {1'b0, rad_q})) begin
            state_d = ST_IDLE;
          end else begin
            dist_d  = dist_w[30:0];
            state_d = ST_SEL;
          end
        end
      end
      // repulsion zone: dist / f - R; otherwise tent scaled by the table
      ST_SEL: begin
        ureq.start = 1'b1;
        if (dist_q <= rr_q) begin
          usrc    = {1'b0, dist_q, 32'b0};
          uden    = {16'b0, frac_q};
          state_d = ST_DR;
        end else begin
          usrc    = {arg_mag[31:0], 32'b0};
          uden    = {15'b0, 17'h10000 - {1'b0, frac_q}};
          state_d = ST_DA;
        end
      end
      ST_DR: begin
        if (ustat.done) begin
          s_d     = signed'({1'b0, ures[30:0]}) - signed'({1'b0, rad_q});
          state_d = ST_UXS;
        end
      end
      ST_DA: begin
        if (ustat.done) begin
          t_d     = sat32(50'(rm));
          state_d = ST_DT;
        end
      end
      ST_DT: begin
        mul_en  = 1'b1;
        mul_a   = {1'b0, t_mag};
        mul_b   = sc_mag;
        sg_d    = t_q[31] ^ scale[31];
        state_d = ST_DS;
      end
      ST_DS: begin
        s_d     = sat32(apply_sign(prod_q[64:16], sg_q));
        state_d = ST_UXS;
      end

      // unit vector and accumulate, x then y
      ST_UXS: begin
        ureq.start = 1'b1;
        usrc       = {1'b0, adx_q, 32'b0};
        uden       = {1'b0, dist_q};
        state_d    = ST_UXW;
      end
      ST_UXW, ST_UYW: begin
        if (ustat.done) begin
          mul_en  = 1'b1;
          mul_a   = {1'b0, s_mag};
          mul_b   = {15'b0, ures[16:0]};
          sg_d    = s_q[31] ^ ((state_q == ST_UXW) ? sx_q : sy_q);
          state_d = (state_q == ST_UXW) ? ST_FXN : ST_FYN;
        end
      end
      ST_FXN: begin
        acc_x_d    = sat32(50'(acc_x_q) + apply_sign(prod_q[64:16], sg_q));
        ureq.start = 1'b1;
        usrc       = {1'b0, ady_q, 32'b0};
        uden       = {1'b0, dist_q};
        state_d    = ST_UYW;
      end
      ST_FYN: begin
        acc_y_d = sat32(50'(acc_y_q) + apply_sign(prod_q[64:16], sg_q));
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      own_x_q     <= '0;
      own_y_q     <= '0;
      own_col_q   <= '0;
      own_id_q    <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      own_x_q     <= own_x_d;
      own_y_q     <= own_y_d;
      own_col_q   <= own_col_d;
      own_id_q    <= own_id_d;
      acc_x_q     <= acc_x_d;
      acc_y_q     <= acc_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_px_q  <= it_px_d;
    it_py_q  <= it_py_d;
    it_prx_q <= it_prx_d;
    it_pry_q <= it_pry_d;
    it_col_q <= it_col_d;
    it_id_q  <= it_id_d;
    sg_q   <= sg_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    adx_q  <= adx_d;
    ady_q  <= ady_d;
    d2_q   <= d2_d;
    rr_q   <= rr_d;
    dist_q <= dist_d;
    t_q    <= t_d;
    s_q    <= s_d;
    fx_q   <= fx_d;
    fy_q   <= fy_d;
    rid_q  <= rid_d;
    if (mul_en) begin
      prod_q <= prod_d;
    end
  end

  pcfa_iter_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ureq),
    .src_i  (usrc),
    .den_i  (uden),
    .stat_o (ustat),
    .res_o  (ures)
  );

  pcfa_scale_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_scale_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_i.scale_value),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== rtl/pcfa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfa_checker: port-level checks for the force accumulator
// Result channel stability, item/result ordering and input busy after start or neighbor.
// ----------------------------------------------------------------------------
module pcfa_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic [1:0]         in_op_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [31:0] out_force_x_i,
  input logic signed [31:0] out_force_y_i,
  input logic [11:0]        out_result_id_i
);
  import pcfa_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_force_x_i) && $stable(out_force_y_i)
      && $stable(out_result_id_i))
    else $error("result changed while stalled");

  a_result_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && (in_op_i == OP_FINISH)))
    else $error("result without a finish transfer");

  a_busy_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && ((in_op_i == OP_START) || (in_op_i == OP_NEIGHBOR))
      |=> !in_ready_i)
    else $error("input ready while start or neighbor in progress");

endmodule

bind pairwise_color_force_accumulator pcfa_checker u_pcfa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_op_i         (in_i.op),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_force_x_i   (out_o.force_x),
  .out_force_y_i   (out_o.force_y),
  .out_result_id_i (out_o.result_id)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for pairwise_color_force_accumulator
// Drives load/start/neighbor/finish transfers through the item channel with
// random gaps, predicts each particle's net force in Q16.16 bit for bit, and
// checks every force transfer on the result channel in order. The register
// settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import pcfa_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 400;  // lets a neighbor in flight drain

  typedef struct {
    op_e                op;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
    logic [3:0]         color;
    logic [3:0]         column_color;
    logic [11:0]        particle_id;
    logic signed [31:0] scale_value;
  } item_t;

  typedef struct {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic [11:0]        result_id;
  } force_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  pcfa_in_if  in_ch ();
  pcfa_out_if out_ch ();

  pairwise_color_force_accumulator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // stimulus and scoreboard stores
  item_t  pending_items[$];
  force_t expected_forces[$];
  int     mismatches;
  int unsigned cycles;

  // idling knobs, percent of cycles
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int          rx_stall_req;
  int          rx_stall_seen;
  int unsigned rx_stall_left;

  // ---------------------------------------------------------------------------
  // predictor state: configuration, color-pair scale table, particle latches
  // ---------------------------------------------------------------------------
  longint cfg_half_width, cfg_radius, cfg_rep_frac, cfg_friction, cfg_inv_dt;
  longint scale_tbl[256];
  longint own_px, own_py, force_acc_x, force_acc_y;
  logic [3:0]  own_col;
  logic [11:0] own_pid;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Q16.16 product, truncated toward zero
  function automatic longint qprod(longint a, longint b);
    longint unsigned p;
    p = (magnitude(a) * magnitude(b)) >> 16;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint wrap_offset(longint d);
    if (d > cfg_half_width) d = d - 2 * cfg_half_width;
    if (d < -cfg_half_width) d = d + 2 * cfg_half_width;
    return d;
  endfunction

  function automatic longint friction_seed(longint pos, longint prev);
    longint vel;
    vel = clip32(qprod(pos - prev, cfg_inv_dt));
    return clip32(-qprod(vel, cfg_friction));
  endfunction

  task automatic add_pair_force(item_t it);
    longint dx, dy, sep, rr, s, q, t, ux, uy;
    if (it.particle_id == own_pid) return;  // a particle never pushes itself
    dx = wrap_offset(longint'(it.px) - own_px);
    dy = wrap_offset(longint'(it.py) - own_py);
    if (longint'(magnitude(dx)) > cfg_radius || longint'(magnitude(dy)) > cfg_radius) return;
    sep = longint'(root_floor(magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy)));
    if (sep == 0 || sep > cfg_radius) return;  // coincident: no direction
    rr = (cfg_rep_frac * cfg_radius) >> 16;
    if (sep <= rr) begin
      s = (sep * 65536) / cfg_rep_frac - cfg_radius;
    end else begin
      q = ((2 * sep - cfg_radius - rr) * 65536) / (65536 - cfg_rep_frac);
      t = clip32(cfg_radius - longint'(magnitude(q)));
      s = clip32(qprod(t, scale_tbl[{own_col, it.color}]));
    end
    ux = (dx * 65536) / sep;
    uy = (dy * 65536) / sep;
    force_acc_x = clip32(force_acc_x + qprod(s, ux));
    force_acc_y = clip32(force_acc_y + qprod(s, uy));
  endtask

  task automatic apply_item(item_t it);
    force_t f;
    case (it.op)
      OP_LOAD: scale_tbl[{it.color, it.column_color}] = longint'(it.scale_value);
      OP_START: begin
        own_px = longint'(it.px);
        own_py = longint'(it.py);
        own_col = it.color;
        own_pid = it.particle_id;
        force_acc_x = friction_seed(longint'(it.px), longint'(it.prev_x));
        force_acc_y = friction_seed(longint'(it.py), longint'(it.prev_y));
      end
      OP_NEIGHBOR: add_pair_force(it);
      default: begin
        f.force_x = force_acc_x[31:0];
        f.force_y = force_acc_y[31:0];
        f.result_id = own_pid;
        expected_forces.insert(expected_forces.size(), f);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // clock, reset, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: pops the next pending item once the channel slot is free
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    item_t it;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        it = pending_items.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.op           <= it.op;
        in_ch.px           <= it.px;
        in_ch.py           <= it.py;
        in_ch.prev_x       <= it.prev_x;
        in_ch.prev_y       <= it.prev_y;
        in_ch.color        <= it.color;
        in_ch.column_color <= it.column_color;
        in_ch.particle_id  <= it.particle_id;
        in_ch.scale_value  <= it.scale_value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // every accepted item goes through the predictor, sampled before the edge
  always @(posedge clk_i) begin
    item_t it;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      it.op = op_e'(in_ch.op);
      it.px = in_ch.px;
      it.py = in_ch.py;
      it.prev_x = in_ch.prev_x;
      it.prev_y = in_ch.prev_y;
      it.color = in_ch.color;
      it.column_color = in_ch.column_color;
      it.particle_id = in_ch.particle_id;
      it.scale_value = in_ch.scale_value;
      apply_item(it);
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random back-pressure plus on-demand long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      rx_stall_seen <= 0;
      rx_stall_left <= 0;
    end else if (rx_stall_req != rx_stall_seen) begin
      rx_stall_seen <= rx_stall_req;
      rx_stall_left <= 3000;
      out_ch.ready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // monitor: compare each force transfer against the oldest prediction
  always @(posedge clk_i) begin
    force_t exp_f;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_forces.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("[%0t] unexpected force transfer id=%0d", $realtime, out_ch.result_id);
      end else begin
        exp_f = expected_forces.pop_front();
        if (out_ch.force_x !== exp_f.force_x || out_ch.force_y !== exp_f.force_y ||
            out_ch.result_id !== exp_f.result_id) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("[%0t] force mismatch: exp x=%h y=%h id=%0d, got x=%h y=%h id=%0d",
                     $realtime, exp_f.force_x, exp_f.force_y, exp_f.result_id,
                     out_ch.force_x, out_ch.force_y, out_ch.result_id);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus generation; mirrors own color/position so every table entry a
  // neighbor can read has been loaded first
  // ---------------------------------------------------------------------------
  bit          tbl_loaded[256];
  logic [3:0]  gen_col;
  logic [11:0] gen_pid;
  logic signed [31:0] gen_px, gen_py;
  longint      gen_radius;

  function automatic item_t random_item(op_e op);
    item_t it;
    it.op = op;
    it.px = $urandom;
    it.py = $urandom;
    it.prev_x = $urandom;
    it.prev_y = $urandom;
    it.color = 4'($urandom);
    it.column_color = 4'($urandom);
    it.particle_id = 12'($urandom);
    it.scale_value = $urandom;
    return it;
  endfunction

  task automatic queue_load(logic [3:0] row, logic [3:0] col, logic signed [31:0] val);
    item_t it;
    it = random_item(OP_LOAD);
    it.color = row;
    it.column_color = col;
    it.scale_value = val;
    tbl_loaded[{row, col}] = 1'b1;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic queue_start(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] ox, logic signed [31:0] oy,
                             logic [3:0] col, logic [11:0] pid);
    item_t it;
    it = random_item(OP_START);
    it.px = x;
    it.py = y;
    it.prev_x = ox;
    it.prev_y = oy;
    it.color = col;
    it.particle_id = pid;
    gen_px = x;
    gen_py = y;
    gen_col = col;
    gen_pid = pid;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic queue_neighbor(logic signed [31:0] x, logic signed [31:0] y,
                                logic [3:0] col, logic [11:0] pid);
    item_t it;
    if (!tbl_loaded[{gen_col, col}]) queue_load(gen_col, col, $urandom);
    it = random_item(OP_NEIGHBOR);
    it.px = x;
    it.py = y;
    it.color = col;
    it.particle_id = pid;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic queue_finish();
    pending_items.insert(pending_items.size(), random_item(OP_FINISH));
  endtask

  // neighbor offset mostly inside the interaction radius, sometimes random
  function automatic logic signed [31:0] near_coord(logic signed [31:0] base);
    longint span;
    longint off;
    if ($urandom_range(9) == 0) return $urandom;
    span = gen_radius + gen_radius / 4;
    if (span > 64'sd2147483647) span = 64'sd2147483647;
    off = longint'($urandom_range(0, 32'(2 * span))) - span;
    return base + 32'(off);
  endfunction

  task automatic queue_random_particles(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 12) begin
        // noise: any op with unconstrained fields
        case ($urandom_range(3))
          0: queue_load(4'($urandom), 4'($urandom), $urandom);
          1: queue_start($urandom, $urandom, $urandom, $urandom, 4'($urandom),
                         12'($urandom));
          2: queue_neighbor($urandom, $urandom, 4'($urandom), 12'($urandom));
          default: queue_finish();
        endcase
      end else begin
        queue_start($urandom, $urandom, $urandom, $urandom, 4'($urandom), 12'($urandom));
        k = $urandom_range(6);
        for (int j = 0; j < k; j++) begin
          if ($urandom_range(19) == 0)
            queue_neighbor(gen_px, gen_py, 4'($urandom), 12'($urandom));  // coincident
          else if ($urandom_range(19) == 0)
            queue_neighbor(near_coord(gen_px), near_coord(gen_py), 4'($urandom), gen_pid);
          else
            queue_neighbor(near_coord(gen_px), near_coord(gen_py), 4'($urandom),
                           12'($urandom));
        end
        queue_finish();
      end
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_HALF_WIDTH: cfg_half_width = longint'(val);
      REG_RADIUS: begin
        cfg_radius = longint'(val);
        gen_radius = longint'(val);
      end
      REG_REP_FRAC: cfg_rep_frac = longint'(val[15:0]);
      REG_FRICTION: cfg_friction = longint'(val);
      default: cfg_inv_dt = longint'(val);
    endcase
  endtask

  task automatic configure(logic [30:0] w, logic [30:0] r, logic [15:0] f,
                           logic [30:0] fr, logic [30:0] idt);
    write_reg(REG_HALF_WIDTH, w);
    write_reg(REG_RADIUS, r);
    write_reg(REG_REP_FRAC, {15'd0, f});
    write_reg(REG_FRICTION, fr);
    write_reg(REG_INV_DT, idt);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // all items accepted, all forces back, then let a neighbor in flight drain
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pending_items.size() > 0 || in_ch.valid || expected_forces.size() > 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    cycles = 0;
    mismatches = 0;
    src_idle_pct = 10;
    snk_idle_pct = 10;
    rx_stall_req = 0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_HALF_WIDTH;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_LOAD;
    in_ch.px = '0;
    in_ch.py = '0;
    in_ch.prev_x = '0;
    in_ch.prev_y = '0;
    in_ch.color = '0;
    in_ch.column_color = '0;
    in_ch.particle_id = '0;
    in_ch.scale_value = '0;
    out_ch.ready = 1'b0;
    cfg_half_width = longint'(HalfWidthRst);
    cfg_radius = longint'(RadiusRst);
    cfg_rep_frac = longint'(RepFracRst);
    cfg_friction = longint'(FrictionRst);
    cfg_inv_dt = longint'(InvDtRst);
    gen_radius = longint'(RadiusRst);
    own_px = 0;
    own_py = 0;
    force_acc_x = 0;
    force_acc_y = 0;
    own_col = '0;
    own_pid = '0;
    gen_px = '0;
    gen_py = '0;
    gen_col = '0;
    gen_pid = '0;
    foreach (scale_tbl[i]) scale_tbl[i] = 0;
    foreach (tbl_loaded[i]) tbl_loaded[i] = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset settings: neighbor and finish before any start
    queue_neighbor(32'sd3000, -32'sd2000, 4'd5, 12'd7);
    queue_finish();
    queue_load(4'd15, 4'd15, 32'sh7fffffff);
    queue_load(4'd15, 4'd0, 32'sh80000000);
    queue_start(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 4'd15, 12'd4095);
    queue_finish();
    // wrap across the world edge, tent zone, extreme scales
    queue_start(32'sd60000, -32'sd60000, 32'sd60000, -32'sd60000, 4'd15, 12'd0);
    queue_neighbor(-32'sd66000, 32'sd65000, 4'd15, 12'd1);
    queue_neighbor(32'sd64000, -32'sd60000, 4'd0, 12'd2);
    queue_neighbor(32'sd60000, -32'sd60000, 4'd3, 12'd3);   // coincident
    queue_neighbor(32'sd61000, -32'sd60500, 4'd3, 12'd0);   // same id
    queue_neighbor(32'sd60500, -32'sd60000, 4'd3, 12'd4);   // repulsion zone
    queue_neighbor(32'sd70000, -32'sd60000, 4'd3, 12'd5);   // out of radius
    queue_finish();
    queue_finish();
    wait_quiet();

    // settings phases, extremes included
    configure(31'd65536, 31'd6554, 16'd19661, 31'd65536, 31'd3932160);
    queue_random_particles(20);
    wait_quiet();
    configure(31'd1, 31'd1, 16'd1, 31'd0, 31'd1);
    queue_random_particles(15);
    wait_quiet();
    configure(31'h7fffffff, 31'h7fffffff, 16'hffff, 31'h7fffffff, 31'h7fffffff);
    queue_random_particles(15);
    wait_quiet();
    configure(31'd1000000, 31'd200000, 16'd1, 31'd1000, 31'd65536);
    queue_random_particles(15);
    wait_quiet();
    configure(31'd300000, 31'd400000, 16'd65535, 31'd300000, 31'd100);
    queue_random_particles(15);
    wait_quiet();

    // back-pressure: results pile up while the sender keeps going
    src_idle_pct = 0;
    rx_stall_req = rx_stall_req + 1;
    for (int i = 0; i < 20; i++) begin
      queue_start($urandom, $urandom, $urandom, $urandom, 4'($urandom), 12'($urandom));
      queue_finish();
    end
    wait_quiet();

    // long stretch without idling on either side
    snk_idle_pct = 0;
    configure(31'($urandom), 31'($urandom_range(2000, 200000)), 16'($urandom),
              31'($urandom), 31'($urandom));
    queue_random_particles(15);
    wait_quiet();
    src_idle_pct = 10;
    snk_idle_pct = 10;
    configure(31'd65536, 31'd6554, 16'd19661, 31'd65536, 31'd3932160);
    queue_random_particles(15);
    wait_quiet();

    if (mismatches == 0 && expected_forces.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pcfa_pkg.sv
rtl/pcfa_if.sv
rtl/pcfa_iter_unit.sv
rtl/pcfa_scale_mem.sv
rtl/pairwise_color_force_accumulator.sv
rtl/pcfa_checker.sv
dv/tb_top.sv
